[sv/tse_pkg.sv]
// ----------------------------------------------------------------------------
// tse_pkg - shared types and constants of the topological sort engine
// Field widths, reset values and the command passed from front to back.
// ----------------------------------------------------------------------------
package tse_pkg;

  // Fixed field widths of the stream payload
  localparam int VIDX_W   = 5;
  localparam int VCOUNT_W = 6;

  // Defaults
  localparam int                MAX_VERTICES_DEF = 32;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET   = 6'd32;
  localparam int                CMD_FIFO_DEPTH   = 4;

  // Classified request from the front end
  typedef struct packed {
    logic [VIDX_W-1:0] src;
    logic [VIDX_W-1:0] dst;
    logic              has_edge;  // edge is in range and must be stored
    logic              last;      // start the sort after this request
  } cmd_t;

endpackage

[sv/tse_ram.sv]
// ----------------------------------------------------------------------------
// tse_ram - generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/tse_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tse_cmd_fifo - short request queue between front and back end
// Lets the loader keep taking edges while the back end is busy.
// ----------------------------------------------------------------------------
module tse_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tse_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output tse_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import tse_pkg::*;

  localparam int AW = $clog2(CMD_FIFO_DEPTH);

  cmd_t          mem [CMD_FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == (AW + 1)'(CMD_FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/tse_front.sv]
// ----------------------------------------------------------------------------
// tse_front - input classifier
// Checks edge endpoints against the matrix size, drops requests that do
// nothing and queues the rest for the back end.
// ----------------------------------------------------------------------------
module tse_front #(
  parameter int MAX_VERTICES = tse_pkg::MAX_VERTICES_DEF
) (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tse_pkg::VIDX_W-1:0] src_vertex,
  input  logic [tse_pkg::VIDX_W-1:0] dst_vertex,
  input  logic                      edge_valid,
  input  logic                      last_item,
  input  logic                      q_full,
  output logic                      q_push,
  output tse_pkg::cmd_t             q_cmd
);
  import tse_pkg::*;

  logic edge_ok;

  // endpoints outside the matrix are ignored
  assign edge_ok = edge_valid
                && (32'(src_vertex) < MAX_VERTICES)
                && (32'(dst_vertex) < MAX_VERTICES);

  // accept whenever the queue has room; only useful requests enter it
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && (edge_ok || last_item);

  assign q_cmd.src      = src_vertex;
  assign q_cmd.dst      = dst_vertex;
  assign q_cmd.has_edge = edge_ok;
  assign q_cmd.last     = last_item;

endmodule

[sv/tse_back.sv]
// ----------------------------------------------------------------------------
// tse_back - matrix store and sort sequencer
// Stores edges by read-modify-write, then counts in-degrees, seeds the
// ready stack, and pops and scans vertices one column per cycle.
// ----------------------------------------------------------------------------
module tse_back #(
  parameter int MAX_VERTICES = tse_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [tse_pkg::VCOUNT_W-1:0] vertex_count,
  input  tse_pkg::cmd_t               cmd,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tse_pkg::VIDX_W-1:0]  out_vertex,
  output logic                        out_vertex_valid,
  output logic                        out_last,
  output logic                        out_complete
);
  import tse_pkg::*;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [8:0] {
    ST_LOAD     = 9'b000000001,
    ST_DRAIN    = 9'b000000010,
    ST_COUNT    = 9'b000000100,
    ST_SEED     = 9'b000001000,
    ST_POP      = 9'b000010000,
    ST_POP_WAIT = 9'b000100000,
    ST_ROW_WAIT = 9'b001000000,
    ST_SCAN     = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] n;
  logic [CW-1:0] idx, idx_next;

  // adjacency RAM
  logic                    adj_we;
  logic [VW-1:0]           adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic                    adj_re;
  logic [VW-1:0]           adj_raddr;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic [MAX_VERTICES-1:0] row_valid;

  // edge write pipe with one-deep forwarding
  logic                    issue_edge;
  logic                    s2_valid;
  logic [VW-1:0]           s2_addr;
  logic [VW-1:0]           s2_dst;
  logic                    s2_rvalid;
  logic                    fw_valid;
  logic [VW-1:0]           fw_addr;
  logic [MAX_VERTICES-1:0] fw_data;
  logic [MAX_VERTICES-1:0] edge_base;
  logic [MAX_VERTICES-1:0] edge_row;

  // in-degree lanes
  logic                    issue_cnt;
  logic                    acc_valid;
  logic                    acc_rvalid;
  logic [MAX_VERTICES-1:0] acc_row;
  logic                    lane_clear;
  logic                    lane_dec;
  logic [CW-1:0]           indeg [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] zero_vec;
  logic [MAX_VERTICES-1:0] le1_vec;

  // ready stack
  logic          push_req;
  logic          stk_we;
  logic          stk_re;
  logic [VW-1:0] stk_raddr;
  logic [VW-1:0] stk_rdata;
  logic [CW-1:0] sp;
  logic [CW-1:0] sp_dec;

  // current vertex and job totals
  logic                    pop_take;
  logic                    finish;
  logic [VW-1:0]           pend_v;
  logic                    pend_valid;
  logic [CW-1:0]           emitted;
  logic [MAX_VERTICES-1:0] cur_row;

  // result register
  logic              out_free;
  logic              out_load;
  logic [VIDX_W-1:0] out_vertex_d;
  logic              out_vvalid_d;
  logic              out_last_d;
  logic              out_cmpl_d;

  // effective vertex count saturates at the matrix size
  assign n = (32'(vertex_count) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vertex_count);

  assign sp_dec   = sp - 1'b1;
  assign out_free = !out_valid || out_ready;

  tse_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  tse_ram #(
    .WIDTH (VW),
    .DEPTH (MAX_VERTICES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp[VW-1:0]),
    .wdata (idx[VW-1:0]),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // edge merge: forward the previous write, invalid rows read as zero
  always_comb begin
    if (fw_valid && (fw_addr == s2_addr)) begin
      edge_base = fw_data;
    end else if (s2_rvalid) begin
      edge_base = adj_rdata;
    end else begin
      edge_base = '0;
    end
    edge_row         = edge_base;
    edge_row[s2_dst] = 1'b1;
  end

  assign adj_we    = s2_valid;
  assign adj_waddr = s2_addr;
  assign adj_wdata = edge_row;

  // lane status flags
  assign acc_row = acc_rvalid ? adj_rdata : '0;
  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      zero_vec[k] = (indeg[k] == '0);
      le1_vec[k]  = (indeg[k] <= CW'(1));
    end
  end

  assign stk_we = push_req && (sp < CW'(MAX_VERTICES));

  // sequencer
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    cmd_pop      = 1'b0;
    adj_re       = 1'b0;
    adj_raddr    = '0;
    issue_edge   = 1'b0;
    issue_cnt    = 1'b0;
    lane_clear   = 1'b0;
    lane_dec     = 1'b0;
    push_req     = 1'b0;
    stk_re       = 1'b0;
    stk_raddr    = sp_dec[VW-1:0];
    pop_take     = 1'b0;
    finish       = 1'b0;
    out_load     = 1'b0;
    out_vertex_d = '0;
    out_vvalid_d = 1'b0;
    out_last_d   = 1'b0;
    out_cmpl_d   = 1'b0;
    case (state)
      ST_LOAD: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.has_edge) begin
            adj_re     = 1'b1;
            adj_raddr  = VW'(cmd.src);
            issue_edge = 1'b1;
          end
          if (cmd.last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      // last edge write lands; lanes clear
      ST_DRAIN: begin
        lane_clear = 1'b1;
        idx_next   = '0;
        state_next = ST_COUNT;
      end
      // one row per cycle into the in-degree lanes
      ST_COUNT: begin
        if (idx < n) begin
          adj_re    = 1'b1;
          adj_raddr = idx[VW-1:0];
          issue_cnt = 1'b1;
          idx_next  = idx + 1'b1;
        end else if (!acc_valid) begin
          idx_next   = '0;
          state_next = ST_SEED;
        end
      end
      // push zero in-degree vertices in ascending order
      ST_SEED: begin
        if (idx < n) begin
          push_req = zero_vec[idx[VW-1:0]];
          idx_next = idx + 1'b1;
        end else begin
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (sp == '0) begin
          state_next = ST_FINISH;
        end else begin
          stk_re     = 1'b1;
          state_next = ST_POP_WAIT;
        end
      end
      // release the previous vertex as a plain result, fetch the new row
      ST_POP_WAIT: begin
        if (!pend_valid || out_free) begin
          pop_take  = 1'b1;
          adj_re    = 1'b1;
          adj_raddr = stk_rdata;
          if (pend_valid) begin
            out_load     = 1'b1;
            out_vertex_d = VIDX_W'(pend_v);
            out_vvalid_d = 1'b1;
          end
          state_next = ST_ROW_WAIT;
        end
      end
      ST_ROW_WAIT: begin
        idx_next   = '0;
        state_next = ST_SCAN;
      end
      // successors, one column per cycle
      ST_SCAN: begin
        if (idx < n) begin
          lane_dec = 1'b1;
          push_req = cur_row[idx[VW-1:0]] && le1_vec[idx[VW-1:0]];
          idx_next = idx + 1'b1;
        end else begin
          state_next = ST_POP;
        end
      end
      // final result carries the completion flag
      ST_FINISH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_vertex_d = pend_valid ? VIDX_W'(pend_v) : '0;
          out_vvalid_d = pend_valid;
          out_last_d   = 1'b1;
          out_cmpl_d   = (emitted == n);
          finish       = 1'b1;
          state_next   = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      idx        <= '0;
      s2_valid   <= 1'b0;
      fw_valid   <= 1'b0;
      acc_valid  <= 1'b0;
      row_valid  <= '0;
      sp         <= '0;
      emitted    <= '0;
      pend_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      s2_valid  <= issue_edge;
      fw_valid  <= s2_valid;
      acc_valid <= issue_cnt;
      if (finish) begin
        row_valid <= '0;
      end else if (s2_valid) begin
        row_valid[s2_addr] <= 1'b1;
      end
      if (finish) begin
        sp <= '0;
      end else if (stk_re) begin
        sp <= sp_dec;
      end else if (stk_we) begin
        sp <= sp + 1'b1;
      end
      if (finish) begin
        emitted    <= '0;
        pend_valid <= 1'b0;
      end else if (pop_take) begin
        emitted    <= emitted + 1'b1;
        pend_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s2_addr    <= VW'(cmd.src);
    s2_dst     <= VW'(cmd.dst);
    s2_rvalid  <= row_valid[VW'(cmd.src)];
    fw_addr    <= s2_addr;
    fw_data    <= edge_row;
    acc_rvalid <= row_valid[idx[VW-1:0]];
    if (pop_take) begin
      pend_v <= stk_rdata;
    end
    if (state == ST_ROW_WAIT) begin
      cur_row <= row_valid[pend_v] ? adj_rdata : '0;
    end
  end

  // in-degree lanes
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      if (lane_clear) begin
        indeg[k] <= '0;
      end else if (acc_valid && acc_row[k]) begin
        indeg[k] <= indeg[k] + 1'b1;
      end else if (lane_dec && (idx[VW-1:0] == VW'(k)) && cur_row[k] && !zero_vec[k]) begin
        indeg[k] <= indeg[k] - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vertex       <= out_vertex_d;
      out_vertex_valid <= out_vvalid_d;
      out_last         <= out_last_d;
      out_complete     <= out_cmpl_d;
    end
  end

endmodule

[sv/topological_sort_engine_core.sv]
// ----------------------------------------------------------------------------
// topological_sort_engine_core - edge loader and stack-based topological sort
// Edges fill an adjacency bit matrix; the request marked last starts a sort
// that streams vertices in topological order.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          tdata: src, dst; tuser: edge_valid;
//                                         tlast: last_item
//   m_axis    out  tvalid/tready          tdata: out_vertex, complete;
//                                         tuser: vertex_valid; tlast: last_result
//   cfg       in   cfg_valid/cfg_ready    cfg_data: vertex_count
//
// Edge requests are taken one per cycle while the request queue has room; the
// read-modify-write of a matrix row is pipelined with forwarding of the previous write.
// A sort lands the last edge, counts the in-degrees row by row, seeds the
// ready stack, then for each emitted vertex pops it from the stack and
// scans its successors one column per cycle, and finally closes the job.
// Reset clears the control state and the per-row valid bits of the matrix;
// no clearing pass is run, and all row valid bits are cleared together at
// the end of each sort.
// Output backpressure stalls the sequencer; the request queue then fills
// and s_axis_tready drops.
// ----------------------------------------------------------------------------
module topological_sort_engine_core #(
  parameter int MAX_VERTICES = tse_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [4:0] src_vertex, [9:5] dst_vertex
  input  logic                        s_axis_tuser,  // [0] edge_valid
  input  logic                        s_axis_tlast,
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [4:0] out_vertex, [5] complete
  output logic                        m_axis_tuser,  // [0] vertex_valid
  output logic                        m_axis_tlast,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tse_pkg::VCOUNT_W-1:0] cfg_data
);
  import tse_pkg::*;

  logic [VCOUNT_W-1:0] vertex_count;
  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  cmd_t                q_in;
  cmd_t                q_out;
  logic [VIDX_W-1:0]   res_vertex;
  logic                res_complete;

  // vertex count register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_valid) begin
      vertex_count <= cfg_data;
    end
  end

  tse_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .src_vertex (s_axis_tdata[4:0]),
    .dst_vertex (s_axis_tdata[9:5]),
    .edge_valid (s_axis_tuser),
    .last_item  (s_axis_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_in)
  );

  tse_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .empty    (q_empty)
  );

  tse_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .vertex_count     (vertex_count),
    .cmd              (q_out),
    .cmd_empty        (q_empty),
    .cmd_pop          (q_pop),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_vertex       (res_vertex),
    .out_vertex_valid (m_axis_tuser),
    .out_last         (m_axis_tlast),
    .out_complete     (res_complete)
  );

  assign m_axis_tdata = {2'b00, res_complete, res_vertex};

endmodule
